// ===== rtl/open_address_id_lookup_defines.svh =====
// assertion macros for the open address id lookup block
// included by files that carry concurrent checks; no other dependencies
`ifndef OPEN_ADDRESS_ID_LOOKUP_DEFINES_SVH
`define OPEN_ADDRESS_ID_LOOKUP_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define OAIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define OAIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OAIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OAIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/oail_pkg.sv =====
// shared types and constants for the open address id lookup block
// no dependencies
`timescale 1ns / 1ps

package oail_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int STEP_W      = 12;
    localparam int ID_W        = 16;
    localparam int LOC_W       = 16;
    localparam int DIV_STEPS   = ID_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam logic [ID_W-1:0]   EMPTY_ID   = 16'hFFFF;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] STEP_RESET = 12'd79;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_STEP = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] REASON_MATCH = 2'd0;
    localparam logic [1:0] REASON_EMPTY = 2'd1;
    localparam logic [1:0] REASON_WRAP  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } oail_state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LOC_W-1:0] loc;
    } slot_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } oail_mod_status_t;

endpackage

// ===== rtl/oail_channels.sv =====
// request and response channel interfaces of the open address id lookup block
// depends on oail_pkg
`timescale 1ns / 1ps

interface oail_req_if;
    import oail_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] slot;
    logic [ID_W-1:0]   entry_id;
    logic [LOC_W-1:0]  entry_location;
    logic [ID_W-1:0]   lookup_id;

    modport source (output valid, kind, slot, entry_id, entry_location, lookup_id,
                    input ready);
    modport sink   (input valid, kind, slot, entry_id, entry_location, lookup_id,
                    output ready);
endinterface

interface oail_rsp_if;
    import oail_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [LOC_W-1:0] location;
    logic [1:0]       end_reason;

    modport source (output valid, found, location, end_reason, input ready);
    modport sink   (input valid, found, location, end_reason, output ready);
endinterface

// ===== rtl/oail_mod.sv =====
// bit-serial remainder unit: two dividends by one shared divisor, one bit a cycle
// depends on oail_pkg
`timescale 1ns / 1ps

module oail_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [oail_pkg::ID_W-1:0]      dividend_a,
    input  logic [oail_pkg::STEP_W-1:0]    dividend_b,
    input  logic [oail_pkg::SIZE_W-1:0]    divisor,
    output logic [oail_pkg::ADDR_W-1:0]    rem_a,
    output logic [oail_pkg::ADDR_W-1:0]    rem_b,
    output oail_pkg::oail_mod_status_t     status
);
    import oail_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ID_W-1:0]      a_reg;
    logic [ID_W-1:0]      b_reg;
    logic [ADDR_W-1:0]    ra_reg;
    logic [ADDR_W-1:0]    rb_reg;
    logic [SIZE_W-1:0]    div_reg;
    logic [SIZE_W-1:0]    ta;
    logic [SIZE_W-1:0]    tb;
    logic [ADDR_W-1:0]    ra_next;
    logic [ADDR_W-1:0]    rb_next;

    // partial remainder stays below the divisor, so the shifted value fits
    always_comb
    begin
        ta = {ra_reg, a_reg[ID_W-1]};
        tb = {rb_reg, b_reg[ID_W-1]};
        ra_next = (ta >= div_reg) ? ADDR_W'(ta - div_reg) : ta[ADDR_W-1:0];
        rb_next = (tb >= div_reg) ? ADDR_W'(tb - div_reg) : tb[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= dividend_a;
            b_reg   <= {{(ID_W-STEP_W){1'b0}}, dividend_b};
            ra_reg  <= '0;
            rb_reg  <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            a_reg  <= {a_reg[ID_W-2:0], 1'b0};
            b_reg  <= {b_reg[ID_W-2:0], 1'b0};
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign rem_a       = ra_reg;
    assign rem_b       = rb_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/open_address_id_lookup.sv =====
// Open address id lookup: a 4096-slot table of (id, location) pairs in one
// synchronous memory, searched with a fixed probe stride. After reset the block
// sweeps the memory to the empty marker, one slot a cycle, and takes no item
// meanwhile (configuration writes are taken). A load item is written to the
// memory as it is accepted. A lookup item is accepted, then runs through the
// bit-serial remainder unit for the start slot and the stride, then takes a
// memory read and a compare per probe, and then waits until the output register
// is free and hands the result to it. Only one lookup is in flight; the next
// item is taken as soon as the result sits in the output register.
// depends on oail_pkg, oail_channels, oail_mod and open_address_id_lookup_defines.svh
`timescale 1ns / 1ps
`include "open_address_id_lookup_defines.svh"

module open_address_id_lookup (
    input  logic                              clk,
    input  logic                              rst_n,
    oail_req_if.sink                          req,
    oail_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [oail_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [oail_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import oail_pkg::*;

    oail_state_t       state_reg;
    oail_state_t       state_next;

    logic [SIZE_W-1:0] table_size_reg;
    logic [STEP_W-1:0] probe_step_reg;
    logic [SIZE_W-1:0] size_use;

    slot_entry_t       slot_mem [TABLE_DEPTH];
    slot_entry_t       rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [ID_W-1:0]   lid_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] step_m_reg;
    logic [ADDR_W-1:0] rem_a;
    logic [ADDR_W-1:0] rem_b;
    oail_mod_status_t  mod_stat;

    logic              res_found_reg;
    logic [LOC_W-1:0]  res_loc_reg;
    logic [1:0]        res_reason_reg;
    logic              rsp_valid_reg;
    logic              rsp_found_reg;
    logic [LOC_W-1:0]  rsp_loc_reg;
    logic [1:0]        rsp_reason_reg;

    logic              req_accept;
    logic              mod_start;
    logic              load_ctx;
    logic              step_probe;
    logic              stage_res;
    logic              emit;
    logic              hit;
    logic              empty_hit;
    logic [SIZE_W-1:0] idx_sum;
    logic [ADDR_W-1:0] idx_adv;
    logic              res_found;
    logic [LOC_W-1:0]  res_loc;
    logic [1:0]        res_reason;

    // size in use: zero acts as one, above the depth acts as the depth
    always_comb
    begin
        if (table_size_reg == '0)
            size_use = SIZE_W'(1);
        else if (table_size_reg > SIZE_W'(TABLE_DEPTH))
            size_use = SIZE_W'(TABLE_DEPTH);
        else
            size_use = table_size_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
            probe_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data;
                REG_PROBE_STEP: probe_step_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    oail_mod u_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mod_start),
        .dividend_a (req.lookup_id),
        .dividend_b (probe_step_reg),
        .divisor    (size_use),
        .rem_a      (rem_a),
        .rem_b      (rem_b),
        .status     (mod_stat)
    );

    // slot memory, one write and one registered read port
    assign mem_we    = (state_reg == ST_CLEAR) || (req_accept && req.kind == KIND_LOAD);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : req.slot;
    assign mem_wdata = (state_reg == ST_CLEAR) ? slot_entry_t'{id: EMPTY_ID, loc: '0}
                                               : slot_entry_t'{id: req.entry_id,
                                                               loc: req.entry_location};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= slot_mem[idx_reg];
    end

    assign req_accept = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);

    // probe compare and next slot with wrap by subtraction
    always_comb
    begin
        hit       = (rd_data_reg.id == lid_reg) && (lid_reg != EMPTY_ID);
        empty_hit = (rd_data_reg.id == EMPTY_ID);
        idx_sum   = {1'b0, idx_reg} + {1'b0, step_m_reg};
        idx_adv   = (idx_sum >= size_use) ? ADDR_W'(idx_sum - size_use)
                                          : idx_sum[ADDR_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        mod_start  = 1'b0;
        load_ctx   = 1'b0;
        step_probe = 1'b0;
        stage_res  = 1'b0;
        emit       = 1'b0;
        res_found  = 1'b0;
        res_loc    = '0;
        res_reason = REASON_WRAP;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_accept && req.kind == KIND_LOOKUP)
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    load_ctx   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    stage_res  = 1'b1;
                    res_found  = 1'b1;
                    res_loc    = rd_data_reg.loc;
                    res_reason = REASON_MATCH;
                    state_next = ST_EMIT;
                end
                else if (empty_hit)
                begin
                    stage_res  = 1'b1;
                    res_reason = REASON_EMPTY;
                    state_next = ST_EMIT;
                end
                else if (idx_adv == start_reg)
                begin
                    stage_res  = 1'b1;
                    res_reason = REASON_WRAP;
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_probe = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (emit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_start)
            lid_reg <= req.lookup_id;
        if (load_ctx)
        begin
            start_reg  <= rem_a;
            idx_reg    <= rem_a;
            step_m_reg <= rem_b;
        end
        else if (step_probe)
            idx_reg <= idx_adv;
        if (stage_res)
        begin
            res_found_reg  <= res_found;
            res_loc_reg    <= res_loc;
            res_reason_reg <= res_reason;
        end
        if (emit)
        begin
            rsp_found_reg  <= res_found_reg;
            rsp_loc_reg    <= res_loc_reg;
            rsp_reason_reg <= res_reason_reg;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.location   = rsp_loc_reg;
    assign rsp.end_reason = rsp_reason_reg;

    `OAIL_ASSERT_IMPLY(a_found_is_match, clk, rst_n, rsp.valid && rsp.found, rsp.end_reason == REASON_MATCH)
    `OAIL_ASSERT_IMPLY(a_miss_loc_zero, clk, rst_n, rsp.valid && !rsp.found, rsp.location == '0)
    `OAIL_ASSERT_IMPLY(a_mod_busy_in_mod, clk, rst_n, mod_stat.busy, state_reg == ST_MOD)
    `OAIL_ASSERT_IMPLY(a_probe_in_range, clk, rst_n, state_reg == ST_CHECK, {1'b0, idx_reg} < size_use)
    `OAIL_ASSERT_NEXT(a_clear_holds_off, clk, rst_n, state_reg == ST_CLEAR, !rsp.valid)

endmodule

// ===== tb/open_address_id_lookup_test.sv =====
// self-checking testbench for the open address id lookup block: directed table, then
// random load/lookup phases at several table sizes and strides, with random stalls
// depends on oail_pkg, oail_channels and open_address_id_lookup
`timescale 1ns / 1ps

module open_address_id_lookup_test;
    import oail_pkg::*;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int FIXED_PHASES    = 12;
    localparam int PHASE_COUNT     = 16;
    localparam int HOLD_PHASE      = 2;
    localparam int STEADY_PHASE    = 4;
    localparam int PLAN_ROWS       = 30;

    localparam int PHASE_SIZES [FIXED_PHASES] =
        '{8, 1, 16, 5, 64, 8191, 31, 128, 0, 4096, 2, 40};
    localparam int PHASE_STEPS [FIXED_PHASES] =
        '{3, 1, 4, 10, 79, 4095, 4095, 127, 0, 1, 1, 7};

    typedef struct packed {
        logic             found;
        logic [LOC_W-1:0] location;
        logic [1:0]       end_reason;
    } lookup_result_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] slot;
        logic [ID_W-1:0]   entry_id;
        logic [LOC_W-1:0]  entry_location;
        logic [ID_W-1:0]   lookup_id;
    } table_item_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_LOOKUP,
        OP_SET_SIZE,
        OP_SET_STEP
    } plan_op_t;

    // key is the id for items and the register value for writes
    typedef struct packed {
        plan_op_t          op;
        logic [ADDR_W-1:0] slot;
        logic [ID_W-1:0]   key;
        logic [LOC_W-1:0]  data;
        logic              typed;
        lookup_result_t    result;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    oail_req_if req_ch ();
    oail_rsp_if rsp_ch ();

    open_address_id_lookup uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the slot store and the registers
    logic [ID_W-1:0]   table_ids  [TABLE_DEPTH];
    logic [LOC_W-1:0]  table_locs [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;
    logic [STEP_W-1:0] step_reg = STEP_RESET;

    lookup_result_t  awaited_lookups [$];
    logic [ID_W-1:0] recent_ids [$];
    lookup_result_t  due_result;
    plan_row_t       directed_plan [PLAN_ROWS];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    logic            steady;
    logic            hold_request;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned slots_in_use();
        if (size_reg == 0)
            return 1;
        if (size_reg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return size_reg;
    endfunction

    // walks the probe sequence for one id; stop_slot is where the walk ended
    function automatic lookup_result_t probe_table(input logic [ID_W-1:0] want,
                                                   output int unsigned stop_slot);
        int unsigned span;
        int unsigned stride;
        int unsigned start;
        int unsigned idx;
        lookup_result_t res;
        span = slots_in_use();
        stride = step_reg % span;
        start = want % span;
        idx = start;
        res.found = 1'b0;
        res.location = '0;
        res.end_reason = REASON_WRAP;
        stop_slot = start;
        for (int unsigned n = 0; n < span; n++)
        begin
            stop_slot = idx;
            if (table_ids[idx] == want && want != EMPTY_ID)
            begin
                res.found = 1'b1;
                res.location = table_locs[idx];
                res.end_reason = REASON_MATCH;
                return res;
            end
            if (table_ids[idx] == EMPTY_ID)
            begin
                res.end_reason = REASON_EMPTY;
                return res;
            end
            idx += stride;
            if (idx >= span)
                idx -= span;
            if (idx == start)
                return res;
        end
        return res;
    endfunction

    function automatic plan_row_t plan_row(plan_op_t op, logic [ADDR_W-1:0] slot,
                                           logic [ID_W-1:0] key, logic [LOC_W-1:0] data,
                                           logic typed = 1'b0, logic found = 1'b0,
                                           logic [LOC_W-1:0] location = '0,
                                           logic [1:0] end_reason = REASON_MATCH);
        plan_row_t r;
        r.op = op;
        r.slot = slot;
        r.key = key;
        r.data = data;
        r.typed = typed;
        r.result.found = found;
        r.result.location = location;
        r.result.end_reason = end_reason;
        return r;
    endfunction

    task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_lookups.size() != 0)
            @(negedge clk);
        // a load just taken writes its slot at the edge that takes it
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index == REG_TABLE_SIZE)
            size_reg = value[SIZE_W-1:0];
        else
            step_reg = value[STEP_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_item(input table_item_t it, input logic typed,
                              input lookup_result_t typed_result);
        int unsigned ignored_slot;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 12)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= it.kind;
        req_ch.slot           <= it.slot;
        req_ch.entry_id       <= it.entry_id;
        req_ch.entry_location <= it.entry_location;
        req_ch.lookup_id      <= it.lookup_id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (it.kind == KIND_LOAD)
        begin
            table_ids[it.slot]  = it.entry_id;
            table_locs[it.slot] = it.entry_location;
        end
        else if (typed)
            awaited_lookups.push_back(typed_result);
        else
            awaited_lookups.push_back(probe_table(it.lookup_id, ignored_slot));
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_lookups.size() == 0)
            begin
                $error("result item with no lookup outstanding");
                mismatch_count++;
            end
            else
            begin
                due_result = awaited_lookups.pop_front();
                if (rsp_ch.found !== due_result.found)
                begin
                    $error("found: expected %0d, got %0d", due_result.found, rsp_ch.found);
                    mismatch_count++;
                end
                if (rsp_ch.location !== due_result.location)
                begin
                    $error("location: expected %h, got %h",
                           due_result.location, rsp_ch.location);
                    mismatch_count++;
                end
                if (rsp_ch.end_reason !== due_result.end_reason)
                begin
                    $error("end_reason: expected %0d, got %0d",
                           due_result.end_reason, rsp_ch.end_reason);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        table_item_t    it;
        plan_row_t      row_now;
        lookup_result_t probe;
        int unsigned    stop_slot;
        int unsigned    in_use;
        int unsigned    pick;
        int unsigned    sz;
        int unsigned    st;

        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_LOAD;
        req_ch.slot           = '0;
        req_ch.entry_id       = '0;
        req_ch.entry_location = '0;
        req_ch.lookup_id      = '0;
        cfg_we                = 1'b0;
        cfg_index             = REG_TABLE_SIZE;
        cfg_data              = '0;
        steady                = 1'b0;
        hold_request          = 1'b0;
        foreach (table_ids[i])
        begin
            table_ids[i]  = EMPTY_ID;
            table_locs[i] = '0;
        end

        directed_plan = '{
            plan_row(OP_LOOKUP,   12'h000, 16'h0000, 16'h0000, 1, 0, 16'h0000, REASON_EMPTY),
            plan_row(OP_LOOKUP,   12'hFFF, 16'hFFFF, 16'hFFFF, 1, 0, 16'h0000, REASON_EMPTY),
            plan_row(OP_LOAD,     12'h000, 16'h0000, 16'h0000),
            plan_row(OP_LOOKUP,   12'h000, 16'h0000, 16'hFFFF, 1, 1, 16'h0000, REASON_MATCH),
            plan_row(OP_LOAD,     12'hFFF, 16'h0FFF, 16'hFFFF),
            plan_row(OP_LOOKUP,   12'h000, 16'h0FFF, 16'h0000, 1, 1, 16'hFFFF, REASON_MATCH),
            // collides with slot 0, lands one stride on
            plan_row(OP_LOAD,     12'h04F, 16'h1000, 16'h1234),
            plan_row(OP_LOOKUP,   12'h000, 16'h1000, 16'h0000),
            plan_row(OP_LOOKUP,   12'h000, 16'hF000, 16'h0000),
            // empty marker clears the slot, location still written
            plan_row(OP_LOAD,     12'h000, 16'hFFFF, 16'hABCD),
            plan_row(OP_LOOKUP,   12'h000, 16'h1000, 16'h0000, 1, 0, 16'h0000, REASON_EMPTY),
            plan_row(OP_LOAD,     12'hAAA, 16'h5555, 16'hAAAA),
            plan_row(OP_LOAD,     12'h555, 16'hAAAA, 16'h5555),
            plan_row(OP_LOOKUP,   12'h555, 16'h5555, 16'h0000),
            plan_row(OP_LOOKUP,   12'hAAA, 16'hAAAA, 16'h0000),
            // size zero behaves as one slot, zero stride
            plan_row(OP_SET_SIZE, 12'h000, 16'h0000, 16'h0000),
            plan_row(OP_SET_STEP, 12'h000, 16'h0000, 16'h0000),
            plan_row(OP_LOAD,     12'h000, 16'h1234, 16'h0001),
            plan_row(OP_LOOKUP,   12'h000, 16'h1234, 16'h0000, 1, 1, 16'h0001, REASON_MATCH),
            plan_row(OP_LOOKUP,   12'h000, 16'h4321, 16'h0000, 1, 0, 16'h0000, REASON_WRAP),
            plan_row(OP_LOOKUP,   12'h000, 16'hFFFF, 16'h0000, 1, 0, 16'h0000, REASON_WRAP),
            // oversized table clamps to the full store
            plan_row(OP_SET_SIZE, 12'h000, 16'h1FFF, 16'h0000),
            plan_row(OP_SET_STEP, 12'h000, 16'h0FFF, 16'h0000),
            plan_row(OP_LOOKUP,   12'h000, 16'h0FFF, 16'h0000, 1, 1, 16'hFFFF, REASON_MATCH),
            plan_row(OP_LOOKUP,   12'h000, 16'h1FFF, 16'h0000),
            // stride above size, and a load beyond the size in use
            plan_row(OP_SET_SIZE, 12'h000, 16'h0004, 16'h0000),
            plan_row(OP_SET_STEP, 12'h000, 16'h0006, 16'h0000),
            plan_row(OP_LOAD,     12'h064, 16'h0064, 16'h0007),
            plan_row(OP_LOOKUP,   12'h000, 16'h0064, 16'h0000),
            plan_row(OP_LOOKUP,   12'h000, 16'h1234, 16'h0000)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            row_now = directed_plan[i];
            case (row_now.op)
                OP_SET_SIZE:
                    set_register(REG_TABLE_SIZE, row_now.key[CFG_DATA_W-1:0]);
                OP_SET_STEP:
                    set_register(REG_PROBE_STEP, CFG_DATA_W'(row_now.key[STEP_W-1:0]));
                default:
                begin
                    it.kind           = (row_now.op == OP_LOAD) ? KIND_LOAD : KIND_LOOKUP;
                    it.slot           = row_now.slot;
                    it.entry_id       = row_now.key;
                    it.entry_location = row_now.data;
                    it.lookup_id      = row_now.key;
                    offer_item(it, row_now.typed, row_now.result);
                end
            endcase
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                sz = PHASE_SIZES[p];
                st = PHASE_STEPS[p];
            end
            else
            begin
                sz = $urandom_range(2, 64);
                st = $urandom_range(0, 4095);
            end
            set_register(REG_TABLE_SIZE, CFG_DATA_W'(sz));
            set_register(REG_PROBE_STEP, CFG_DATA_W'(st));
            steady = (p == STEADY_PHASE);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;

            repeat (ITEMS_PER_PHASE)
            begin
                in_use            = slots_in_use();
                it.slot           = ADDR_W'($urandom_range(TABLE_DEPTH - 1));
                it.entry_id       = ID_W'($urandom_range(16'hFFFF));
                it.entry_location = LOC_W'($urandom_range(16'hFFFF));
                it.lookup_id      = ID_W'($urandom_range(16'hFFFF));
                if ($urandom_range(99) < 45)
                begin
                    it.kind = KIND_LOAD;
                    if ($urandom_range(9) == 0)
                        it.entry_id = EMPTY_ID;
                    if ($urandom_range(99) >= 15)
                    begin
                        it.slot = ADDR_W'($urandom_range(in_use - 1));
                        // mostly insert where a lookup of this id will go
                        if (it.entry_id != EMPTY_ID && $urandom_range(99) < 75)
                        begin
                            probe = probe_table(it.entry_id, stop_slot);
                            if (probe.end_reason != REASON_WRAP)
                                it.slot = ADDR_W'(stop_slot);
                        end
                    end
                    if (it.entry_id != EMPTY_ID)
                    begin
                        recent_ids.push_back(it.entry_id);
                        if (recent_ids.size() > 32)
                            void'(recent_ids.pop_front());
                    end
                end
                else
                begin
                    it.kind = KIND_LOOKUP;
                    pick = $urandom_range(99);
                    if (pick < 55 && recent_ids.size() != 0)
                        it.lookup_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
                    else if (pick < 65)
                        it.lookup_id = EMPTY_ID;
                end
                offer_item(it, 1'b0, '0);
            end
            steady = 1'b0;
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_lookups.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
